FILE: hdl/slhl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Slider hold-lock detector package
// Shared widths, register indexes, reset values and the configuration type.
// ----------------------------------------------------------------------------
package slhl_pkg;

    localparam int NOW_BITS       = 32;
    localparam int VALUE_BITS     = 10;
    localparam int TOL_BITS       = 8;
    localparam int TIME_BITS      = 16;
    localparam int MIN_LEVEL_BITS = 10;
    localparam int CFG_IDX_BITS   = 2;
    localparam int CFG_DATA_BITS  = 16;

    typedef logic [CFG_IDX_BITS-1:0] t_cfg_idx;

    // Register indexes on the configuration channel.
    localparam t_cfg_idx REG_TOLERANCE    = 2'd0;
    localparam t_cfg_idx REG_LOCK_TIME_MS = 2'd1;
    localparam t_cfg_idx REG_DEBOUNCE_MS  = 2'd2;
    localparam t_cfg_idx REG_MIN_LEVEL    = 2'd3;

    // Register values after reset.
    localparam logic [TOL_BITS-1:0]       RST_TOLERANCE    = 8'd8;
    localparam logic [TIME_BITS-1:0]      RST_LOCK_TIME_MS = 16'd1000;
    localparam logic [TIME_BITS-1:0]      RST_DEBOUNCE_MS  = 16'd500;
    localparam logic [MIN_LEVEL_BITS-1:0] RST_MIN_LEVEL    = 10'd124;

    typedef struct packed {
        logic [TOL_BITS-1:0]       tolerance;
        logic [TIME_BITS-1:0]      lock_time_ms;
        logic [TIME_BITS-1:0]      debounce_ms;
        logic [MIN_LEVEL_BITS-1:0] min_level;
    } t_cfg;

endpackage
`default_nettype wire

FILE: hdl/slhl_ifs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Slider hold-lock detector channel interfaces
// Valid/ready channels for samples, results and configuration writes.
// ----------------------------------------------------------------------------
interface slhl_smp_if #(
    parameter int SAMPLE_BITS = 10
);
    import slhl_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample;
    logic [NOW_BITS-1:0]    now_ms;

    modport source (output valid, output sample, output now_ms, input ready);
    modport sink   (input valid, input sample, input now_ms, output ready);
endinterface

interface slhl_res_if;
    import slhl_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [VALUE_BITS-1:0] value;
    logic                  is_locked;
    logic                  lock_event;
    logic                  unlock_event;

    modport source (output valid, output value, output is_locked, output lock_event,
                    output unlock_event, input ready);
    modport sink   (input valid, input value, input is_locked, input lock_event,
                    input unlock_event, output ready);
endinterface

interface slhl_cfg_if;
    import slhl_pkg::*;

    logic                     valid;
    logic                     ready;
    t_cfg_idx                 index;
    logic [CFG_DATA_BITS-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

FILE: hdl/slider_hold_lock_detector.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Slider hold-lock detector
// Locks a slider reading once it has held still and releases it on re-touch.
// ----------------------------------------------------------------------------
// Usage:
//   i_smp carries one beat per slider sample: the converter reading and its
//   millisecond timestamp. o_res returns exactly one beat per sample: the
//   reported value, the lock flag and the lock and unlock event flags.
//   i_cfg writes the tolerance, lock time, debounce time and minimum level;
//   it is always ready and should only be used while no sample is in flight.
//   An accepted sample is held in the input register, then the step logic
//   (a 32-bit timestamp subtract and compare against the hold state)
//   loads the result register, which presents its beat to the receiver.
//   One sample is accepted per cycle, sustained, while the receiver keeps
//   taking results. When the receiver stalls, the result register holds
//   its beat and the input register can still take one sample if it is
//   empty; after that i_smp.ready falls until the result is taken.
//   Reset (synchronous, active low) empties both registers, unlocks the
//   detector, clears the held value and both timestamps, and restores the
//   register defaults.
// ----------------------------------------------------------------------------
module slider_hold_lock_detector #(
    parameter int SAMPLE_BITS = 10
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    slhl_cfg_if.sink   i_cfg,
    slhl_smp_if.sink   i_smp,
    slhl_res_if.source o_res
);
    import slhl_pkg::*;

    t_cfg w_cfg;

    // Configuration register bank.
    slhl_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    // Datapath: input register, detector state and result register.
    slhl_core #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_smp   (i_smp),
        .o_res   (o_res)
    );

    // A result cannot both lock and unlock the detector.
    a_single_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> !(o_res.lock_event && o_res.unlock_event))
        else $error("lock and unlock event in the same beat");

    // Events must agree with the reported lock flag.
    a_event_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> ((!o_res.lock_event || o_res.is_locked) &&
                         (!o_res.unlock_event || !o_res.is_locked)))
        else $error("event flag disagrees with lock flag");

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res.valid)
        else $error("result valid after reset");

endmodule
`default_nettype wire

FILE: hdl/slhl_cfg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Slider hold-lock detector configuration registers
// Holds tolerance, lock time, debounce time and minimum level.
// ----------------------------------------------------------------------------
module slhl_cfg (
    input  wire           i_clk,
    input  wire           i_rst_n,
    slhl_cfg_if.sink      i_cfg,
    output slhl_pkg::t_cfg o_cfg
);
    import slhl_pkg::*;

    t_cfg r_cfg;

    // Writes never stall.
    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tolerance    <= RST_TOLERANCE;
            r_cfg.lock_time_ms <= RST_LOCK_TIME_MS;
            r_cfg.debounce_ms  <= RST_DEBOUNCE_MS;
            r_cfg.min_level    <= RST_MIN_LEVEL;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_TOLERANCE:    r_cfg.tolerance    <= i_cfg.data[TOL_BITS-1:0];
                REG_LOCK_TIME_MS: r_cfg.lock_time_ms <= i_cfg.data[TIME_BITS-1:0];
                REG_DEBOUNCE_MS:  r_cfg.debounce_ms  <= i_cfg.data[TIME_BITS-1:0];
                REG_MIN_LEVEL:    r_cfg.min_level    <= i_cfg.data[MIN_LEVEL_BITS-1:0];
                default: ;
            endcase
        end
    end

endmodule
`default_nettype wire

FILE: hdl/slhl_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Slider hold-lock detector core
// Input register, hold/lock state, one-pass step logic and result register.
// ----------------------------------------------------------------------------
module slhl_core #(
    parameter int SAMPLE_BITS = 10
) (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  slhl_pkg::t_cfg i_cfg,
    slhl_smp_if.sink       i_smp,
    slhl_res_if.source     o_res
);
    import slhl_pkg::*;

    localparam int CMP_BITS = (SAMPLE_BITS > MIN_LEVEL_BITS) ? SAMPLE_BITS : MIN_LEVEL_BITS;

    // Input register
    logic                   r_in_valid;
    logic [SAMPLE_BITS-1:0] r_smp;
    logic [NOW_BITS-1:0]    r_now;

    // Detector state
    logic                   r_locked;
    logic [SAMPLE_BITS-1:0] r_held;
    logic [NOW_BITS-1:0]    r_hold_start;
    logic [NOW_BITS-1:0]    r_lock_start;
    logic                   n_locked;
    logic [SAMPLE_BITS-1:0] n_held;
    logic [NOW_BITS-1:0]    n_hold_start;
    logic [NOW_BITS-1:0]    n_lock_start;

    // Result register
    logic                   r_out_valid;
    logic [VALUE_BITS-1:0]  r_value;
    logic                   r_is_locked;
    logic                   r_lock_ev;
    logic                   r_unlock_ev;

    logic                   w_out_free;
    logic                   w_fire;
    logic                   w_accept;
    logic                   w_touched;
    logic [SAMPLE_BITS-1:0] w_dist;
    logic [SAMPLE_BITS-1:0] w_tol;
    logic                   w_moved;
    logic                   w_within;
    logic [NOW_BITS-1:0]    w_hold_age;
    logic [NOW_BITS-1:0]    w_lock_age;
    logic                   w_lock_ev;
    logic                   w_unlock_ev;

    assign w_out_free  = !r_out_valid || o_res.ready;
    assign w_fire      = r_in_valid && w_out_free;
    assign i_smp.ready = !r_in_valid || w_out_free;
    assign w_accept    = i_smp.valid && i_smp.ready;

    assign w_touched  = CMP_BITS'(r_smp) > CMP_BITS'(i_cfg.min_level);
    assign w_dist     = (r_smp > r_held) ? (r_smp - r_held) : (r_held - r_smp);
    assign w_tol      = SAMPLE_BITS'(i_cfg.tolerance);
    assign w_moved    = w_dist > w_tol;
    assign w_within   = w_dist < w_tol;
    assign w_hold_age = r_now - r_hold_start;
    assign w_lock_age = r_now - r_lock_start;

    // A moved sample restarts the hold timer, so it can never lock in the
    // same step; locking is therefore only checked when the value held still.
    always_comb begin
        n_locked     = r_locked;
        n_held       = r_held;
        n_hold_start = r_hold_start;
        n_lock_start = r_lock_start;
        w_lock_ev    = 1'b0;
        w_unlock_ev  = 1'b0;
        if (!r_locked) begin
            if (w_touched) begin
                if (w_moved) begin
                    n_held       = r_smp;
                    n_hold_start = r_now;
                end else if (w_hold_age > NOW_BITS'(i_cfg.lock_time_ms) && w_within) begin
                    n_locked     = 1'b1;
                    n_lock_start = r_now;
                    w_lock_ev    = 1'b1;
                end
            end else begin
                n_hold_start = r_now;
            end
        end else if (w_lock_age > NOW_BITS'(i_cfg.debounce_ms) && w_within) begin
            n_locked     = 1'b0;
            n_hold_start = r_now;
            w_unlock_ev  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_locked     <= 1'b0;
            r_held       <= '0;
            r_hold_start <= '0;
            r_lock_start <= '0;
        end else begin
            if (w_accept) begin
                r_in_valid <= 1'b1;
            end else if (w_fire) begin
                r_in_valid <= 1'b0;
            end
            if (w_fire) begin
                r_out_valid  <= 1'b1;
                r_locked     <= n_locked;
                r_held       <= n_held;
                r_hold_start <= n_hold_start;
                r_lock_start <= n_lock_start;
            end else if (o_res.ready) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_smp <= i_smp.sample;
            r_now <= i_smp.now_ms;
        end
        if (w_fire) begin
            r_value     <= n_locked ? VALUE_BITS'(n_held) : VALUE_BITS'(r_smp);
            r_is_locked <= n_locked;
            r_lock_ev   <= w_lock_ev;
            r_unlock_ev <= w_unlock_ev;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.value        = r_value;
    assign o_res.is_locked    = r_is_locked;
    assign o_res.lock_event   = r_lock_ev;
    assign o_res.unlock_event = r_unlock_ev;

endmodule
`default_nettype wire

FILE: test/slider_hold_lock_detector_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slider hold-lock detector testbench
// Drives slider samples through the detector under several register settings.
// It predicts every result beat and checks each one field by field.
// Both channels idle at random, and the result channel is held off once for
// a long stretch.
// ----------------------------------------------------------------------------
module slider_hold_lock_detector_tb;
    import slhl_pkg::*;

    localparam int SAMPLE_BITS   = 10;
    localparam int CYCLE_LIMIT   = 100000;
    localparam int PHASES        = 6;
    localparam int PHASE_SAMPLES = 180;
    localparam int HOLD_OFF_AT   = 300;   // samples taken before the long receiver stall
    localparam int HOLD_OFF_LEN  = 300;   // cycles of that stall
    localparam int CALM_FROM     = 600;   // stretch of samples with no idling on either side
    localparam int CALM_TO       = 800;

    // One result beat as the detector reports it.
    typedef struct packed {
        logic [VALUE_BITS-1:0] value;
        logic                  is_locked;
        logic                  lock_event;
        logic                  unlock_event;
    } t_outcome;

    // One row of the directed sweep. Where fixed is set, the outcome typed in
    // the row is what the result beat must carry; otherwise the predictor decides.
    typedef struct packed {
        logic [SAMPLE_BITS-1:0] sample;
        logic [NOW_BITS-1:0]    now_ms;
        logic                   fixed;
        t_outcome               outcome;
    } t_row;

    localparam int SWEEP_ROWS = 19;

    // Runs under the register defaults: tolerance 8, lock 1000 ms, debounce 500 ms,
    // minimum level 124.
    localparam t_row SWEEP [SWEEP_ROWS] = '{
        // An untouched zero sample right after reset.
        '{10'd0,    32'd0,          1'b1, '{10'd0,    1'b0, 1'b0, 1'b0}},
        // Full-scale touch: the held value moves and the hold timer restarts.
        '{10'd1023, 32'd5,          1'b1, '{10'd1023, 1'b0, 1'b0, 1'b0}},
        // Held for exactly the lock time: not yet enough.
        '{10'd1020, 32'd1005,       1'b0, '{10'd0,    1'b0, 1'b0, 1'b0}},
        // One millisecond more locks it.
        '{10'd1020, 32'd1006,       1'b1, '{10'd1023, 1'b1, 1'b1, 1'b0}},
        // Untouched while locked: the minimum level plays no part.
        '{10'd0,    32'd1100,       1'b0, '{10'd0,    1'b0, 1'b0, 1'b0}},
        // Debounce time reached but not exceeded.
        '{10'd1023, 32'd1506,       1'b0, '{10'd0,    1'b0, 1'b0, 1'b0}},
        // Debounce exceeded with a touch on the held value: unlock.
        '{10'd1023, 32'd1507,       1'b1, '{10'd1023, 1'b0, 1'b0, 1'b1}},
        // Locks again without any movement, then unlocks once the debounce time is exceeded.
        '{10'd1023, 32'd2508,       1'b0, '{10'd0,    1'b0, 1'b0, 1'b0}},
        '{10'd1020, 32'd3009,       1'b0, '{10'd0,    1'b0, 1'b0, 1'b0}},
        // Hold starts just below the top of the timestamp range ...
        '{10'd500,  32'hFFFF_FF00,  1'b0, '{10'd0,    1'b0, 1'b0, 1'b0}},
        // ... and the lock is reached across the wrap.
        '{10'd505,  32'h0000_02F0,  1'b1, '{10'd500,  1'b1, 1'b1, 1'b0}},
        // Debounce passed but the touch is far away: stays locked.
        '{10'd0,    32'd1352,       1'b0, '{10'd0,    1'b0, 1'b0, 1'b0}},
        // Distance one below the tolerance unlocks.
        '{10'd507,  32'd1353,       1'b0, '{10'd0,    1'b0, 1'b0, 1'b0}},
        // A long wait, but the sample has moved, so it cannot lock in this step.
        '{10'd520,  32'd6353,       1'b0, '{10'd0,    1'b0, 1'b0, 1'b0}},
        // Exactly at the minimum level counts as untouched.
        '{10'd124,  32'd8353,       1'b0, '{10'd0,    1'b0, 1'b0, 1'b0}},
        '{10'd125,  32'd8354,       1'b0, '{10'd0,    1'b0, 1'b0, 1'b0}},
        // Distance equal to the tolerance: neither a move nor a lock; one below it then locks.
        '{10'd133,  32'd9355,       1'b0, '{10'd0,    1'b0, 1'b0, 1'b0}},
        '{10'd132,  32'd9356,       1'b0, '{10'd0,    1'b0, 1'b0, 1'b0}},
        // Last timestamp of the range while locked.
        '{10'd1023, 32'hFFFF_FFFF,  1'b1, '{10'd125,  1'b1, 1'b0, 1'b0}}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    slhl_cfg_if                              cfg_if ();
    slhl_smp_if #(.SAMPLE_BITS(SAMPLE_BITS)) smp_if ();
    slhl_res_if                              res_if ();

    slider_hold_lock_detector #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg  (cfg_if),
        .i_smp  (smp_if),
        .o_res  (res_if)
    );

    always #4 i_clk = ~i_clk;

    // Predicted detector state, with the register values the block should hold.
    t_cfg                   live_cfg = '{RST_TOLERANCE, RST_LOCK_TIME_MS, RST_DEBOUNCE_MS,
                                         RST_MIN_LEVEL};
    logic                   lock_on       = 1'b0;
    logic [VALUE_BITS-1:0]  pinned_level  = '0;
    logic [NOW_BITS-1:0]    still_since   = '0;
    logic [NOW_BITS-1:0]    locked_since  = '0;

    t_outcome outcomes_due [$];
    int       samples_taken = 0;
    int       mismatches    = 0;
    int       cycle_count   = 0;

    // Side-band copy of the directed row that travels with each sample beat.
    logic     row_fixed;
    t_outcome row_outcome;

    logic quiet_stretch;
    assign quiet_stretch = (samples_taken >= CALM_FROM) && (samples_taken < CALM_TO);

    function automatic logic [VALUE_BITS-1:0] spread(input logic [VALUE_BITS-1:0] a,
                                                     input logic [VALUE_BITS-1:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    // Advances the predicted state by one sample and returns the beat it must give.
    function automatic t_outcome advance_detector(input logic [SAMPLE_BITS-1:0] smp,
                                                  input logic [NOW_BITS-1:0] now);
        t_outcome            res;
        logic [NOW_BITS-1:0] elapsed;
        res = '0;
        if (!lock_on) begin
            if (smp > live_cfg.min_level) begin
                // A touch that moves beyond the tolerance becomes the new held value.
                if (spread(smp, pinned_level) > live_cfg.tolerance) begin
                    pinned_level = smp;
                    still_since  = now;
                end
                elapsed = now - still_since;
                if (elapsed > NOW_BITS'(live_cfg.lock_time_ms) &&
                        spread(smp, pinned_level) < live_cfg.tolerance) begin
                    lock_on        = 1'b1;
                    locked_since   = now;
                    res.lock_event = 1'b1;
                end
            end else begin
                still_since = now;
            end
        end else begin
            elapsed = now - locked_since;
            if (elapsed > NOW_BITS'(live_cfg.debounce_ms) &&
                    spread(smp, pinned_level) < live_cfg.tolerance) begin
                lock_on          = 1'b0;
                still_since      = now;
                res.unlock_event = 1'b1;
            end
        end
        res.value     = lock_on ? pinned_level : smp;
        res.is_locked = lock_on;
        return res;
    endfunction

    // Every accepted sample beat queues the result it must produce.
    always @(posedge i_clk) begin : take_sample
        t_outcome predicted;
        if (i_rst_n && smp_if.valid && smp_if.ready) begin
            predicted = advance_detector(smp_if.sample, smp_if.now_ms);
            outcomes_due.push_back(row_fixed ? row_outcome : predicted);
            samples_taken++;
        end
    end

    // Register writes update the predicted configuration; only the register width is kept.
    always @(posedge i_clk) begin
        if (i_rst_n && cfg_if.valid && cfg_if.ready) begin
            case (cfg_if.index)
                REG_TOLERANCE:    live_cfg.tolerance    = cfg_if.data[TOL_BITS-1:0];
                REG_LOCK_TIME_MS: live_cfg.lock_time_ms = cfg_if.data[TIME_BITS-1:0];
                REG_DEBOUNCE_MS:  live_cfg.debounce_ms  = cfg_if.data[TIME_BITS-1:0];
                REG_MIN_LEVEL:    live_cfg.min_level    = cfg_if.data[MIN_LEVEL_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Each result beat is compared with the oldest outstanding prediction.
    always @(posedge i_clk) begin : check_result
        t_outcome due;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (outcomes_due.size() == 0) begin
                $error("result beat with no sample outstanding: value %0d", res_if.value);
                mismatches++;
            end else begin
                due = outcomes_due.pop_front();
                if (res_if.value !== due.value) begin
                    $error("value: expected %0d, got %0d", due.value, res_if.value);
                    mismatches++;
                end
                if (res_if.is_locked !== due.is_locked) begin
                    $error("is_locked: expected %0b, got %0b", due.is_locked, res_if.is_locked);
                    mismatches++;
                end
                if (res_if.lock_event !== due.lock_event) begin
                    $error("lock_event: expected %0b, got %0b", due.lock_event,
                           res_if.lock_event);
                    mismatches++;
                end
                if (res_if.unlock_event !== due.unlock_event) begin
                    $error("unlock_event: expected %0b, got %0b", due.unlock_event,
                           res_if.unlock_event);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog. Should anything hang, the run is stopped here.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("slider_hold_lock_detector_tb failed");
            $finish;
        end
    end

    // Result receiver: random stalls, none during the calm stretch, and one long
    // hold-off so that both pipeline registers fill and the sample input stalls.
    initial begin : receiver
        bit held_off;
        held_off     = 1'b0;
        res_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (!held_off && samples_taken >= HOLD_OFF_AT) begin
                held_off = 1'b1;
                res_if.ready <= 1'b0;
                repeat (HOLD_OFF_LEN) @(posedge i_clk);
            end
            res_if.ready <= quiet_stretch || ($urandom_range(0, 99) >= 6);
        end
    end

    // Presents one sample beat and returns at the edge where it is taken.
    // The valid line is left high so that the next beat can follow at once.
    task automatic offer_sample(input logic [SAMPLE_BITS-1:0] smp,
                                input logic [NOW_BITS-1:0] now,
                                input logic fixed, input t_outcome outcome);
        smp_if.valid  <= 1'b1;
        smp_if.sample <= smp;
        smp_if.now_ms <= now;
        row_fixed     <= fixed;
        row_outcome   <= outcome;
        do @(posedge i_clk); while (!smp_if.ready);
    endtask

    // Occasionally lets the sample channel go quiet, but never during the calm stretch.
    task automatic maybe_pause();
        if (!quiet_stretch && $urandom_range(0, 99) < 3) begin
            smp_if.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
    endtask

    // Waits until every result has come back, then idles the pipeline before returning.
    // The first edge lets the beat taken at the calling edge reach the queue.
    task automatic settle();
        smp_if.valid <= 1'b0;
        @(posedge i_clk);
        while (outcomes_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Writes all four registers in back-to-back beats. With junk set, the bits
    // above each register's width carry rubbish that the block must drop.
    task automatic apply_config(input t_cfg c, input bit junk);
        for (int k = 0; k < 4; k++) begin
            cfg_if.valid <= 1'b1;
            cfg_if.index <= t_cfg_idx'(k);
            case (t_cfg_idx'(k))
                REG_TOLERANCE:    cfg_if.data <= {junk ? 8'hA5 : 8'h00, c.tolerance};
                REG_LOCK_TIME_MS: cfg_if.data <= c.lock_time_ms;
                REG_DEBOUNCE_MS:  cfg_if.data <= c.debounce_ms;
                default:          cfg_if.data <= {junk ? 6'h2B : 6'h00, c.min_level};
            endcase
            do @(posedge i_clk); while (!cfg_if.ready);
        end
        cfg_if.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin : stimulus
        t_cfg                phase_cfg;
        logic [NOW_BITS-1:0] clock_ms;
        int                  pos;
        int                  jit;
        int                  span;
        int                  smp;
        int                  roll;

        // Every input is known from time zero.
        i_rst_n       = 1'b0;
        cfg_if.valid  = 1'b0;
        cfg_if.index  = REG_TOLERANCE;
        cfg_if.data   = '0;
        smp_if.valid  = 1'b0;
        smp_if.sample = '0;
        smp_if.now_ms = '0;
        row_fixed     = 1'b0;
        row_outcome   = '0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed sweep under the register defaults.
        for (int r = 0; r < SWEEP_ROWS; r++) begin
            maybe_pause();
            offer_sample(SWEEP[r].sample, SWEEP[r].now_ms, SWEEP[r].fixed, SWEEP[r].outcome);
        end

        // Random phases. The first keeps the defaults; the others cover the extremes,
        // a short-timing setting and a random one, both written with junk in the upper bits.
        clock_ms  = $urandom;
        phase_cfg = live_cfg;
        for (int phase = 0; phase < PHASES; phase++) begin
            if (phase > 0) begin
                settle();
                case (phase)
                    1: phase_cfg = '{8'd0,   16'd0,     16'd0,     10'd0};
                    2: phase_cfg = '{8'd255, 16'd65535, 16'd65535, 10'd0};
                    3: phase_cfg = '{8'd16,  16'd50,    16'd20,    10'd300};
                    4: phase_cfg = '{8'd3,   16'd0,     16'd65535, 10'd1023};
                    default: phase_cfg = '{8'($urandom_range(0, 255)),
                                           16'($urandom_range(0, 3000)),
                                           16'($urandom_range(0, 3000)),
                                           10'($urandom_range(0, 600))};
                endcase
                apply_config(phase_cfg, phase == 3 || phase == 5);
            end

            // Time advances in random steps of up to about a third of the longer wait, so a
            // steady finger locks and then unlocks within a handful of samples.
            span = ((phase_cfg.lock_time_ms > phase_cfg.debounce_ms) ?
                    int'(phase_cfg.lock_time_ms) : int'(phase_cfg.debounce_ms)) / 3 + 2;
            jit  = int'(phase_cfg.tolerance) / 2;
            pos  = $urandom_range(0, 1023);

            for (int n = 0; n < PHASE_SAMPLES; n++) begin
                roll = $urandom_range(0, 99);
                if (roll < 4) begin
                    clock_ms = $urandom;           // a jump anywhere, wrap included
                end else if (roll >= 12) begin
                    clock_ms = clock_ms + $urandom_range(0, span);
                end

                roll = $urandom_range(0, 99);
                if (roll < 8) begin
                    smp = $urandom_range(0, phase_cfg.min_level);
                end else if (roll < 13) begin
                    // The finger lands somewhere new, above the minimum level if it can.
                    pos = (phase_cfg.min_level < 10'd1023) ?
                          int'($urandom_range(int'(phase_cfg.min_level) + 1, 1023)) :
                          int'($urandom_range(0, 1023));
                    smp = pos;
                end else if (roll < 17) begin
                    smp = $urandom_range(0, 1023);
                end else begin
                    // Small jitter around the resting finger, inside the tolerance.
                    smp = pos + int'($urandom_range(0, 2 * jit)) - jit;
                    if (smp < 0) begin
                        smp = 0;
                    end else if (smp > 1023) begin
                        smp = 1023;
                    end
                end

                maybe_pause();
                offer_sample(SAMPLE_BITS'(smp), clock_ms, 1'b0, '0);
            end
        end

        settle();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("slider_hold_lock_detector_tb passed");
        end else begin
            $display("slider_hold_lock_detector_tb failed");
        end
        $finish;
    end

endmodule

FILE: slider_hold_lock_detector.f
hdl/slhl_pkg.sv
hdl/slhl_ifs.sv
hdl/slhl_cfg.sv
hdl/slhl_core.sv
hdl/slider_hold_lock_detector.sv
test/slider_hold_lock_detector_tb.sv
